@@ src/tbt_pkg.sv @@
// Shared types, constants and the log2 mantissa table for the thermistor core.
// No dependencies; every other file imports this package.
`default_nettype none

package tbt_pkg;

    localparam int ADC_BITS_DEF = 16;
    localparam int SAMPLE_W     = 16;
    localparam int RATIO_W      = 24;
    localparam int BETA_W       = 20;
    localparam int TEMP_W       = 16;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 24;
    localparam int LOG_W        = 21;
    localparam int Y_W          = 23;
    localparam int D_W          = 46;
    localparam int NUM_W        = 59;
    localparam int N_W          = 60;
    localparam int QUO_W        = 16;

    localparam logic [23:0] LN2_Q24 = 24'd11629080;

    localparam logic [CFG_IDX_W-1:0] REG_REF_RATIO = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BETA_K    = CFG_IDX_W'(1);

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RD_ERR  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAT     = 2'd3;

    typedef enum logic [1:0] {
        DIV_NORM = 2'd0,
        DIV_ZERO = 2'd1,
        DIV_MAX  = 2'd2
    } div_code_t;

    typedef struct packed {
        logic invalid;
        logic rd_err;
    } side_t;

    function automatic logic [16:0] log2_tab(input logic [4:0] idx);
        logic [16:0] val;
        case (idx)
            5'd0:    val = 17'd0;
            5'd1:    val = 17'd5732;
            5'd2:    val = 17'd11136;
            5'd3:    val = 17'd16248;
            5'd4:    val = 17'd21098;
            5'd5:    val = 17'd25711;
            5'd6:    val = 17'd30109;
            5'd7:    val = 17'd34312;
            5'd8:    val = 17'd38336;
            5'd9:    val = 17'd42196;
            5'd10:   val = 17'd45904;
            5'd11:   val = 17'd49472;
            5'd12:   val = 17'd52911;
            5'd13:   val = 17'd56229;
            5'd14:   val = 17'd59434;
            5'd15:   val = 17'd62534;
            default: val = 17'd65536;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

@@ src/tbt_if.sv @@
// Channel interfaces: sample input, temperature result and register write.
// Depends on tbt_pkg for field widths.
`default_nettype none

interface tbt_sample_if;
    import tbt_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] adc_sample;
    logic                adc_read_error;
    modport source (output valid, adc_sample, adc_read_error, input ready);
    modport sink (input valid, adc_sample, adc_read_error, output ready);
endinterface

interface tbt_result_if;
    import tbt_pkg::*;
    logic                valid;
    logic                ready;
    logic [TEMP_W-1:0]   temperature_k;
    logic [STATUS_W-1:0] status;
    modport source (output valid, temperature_k, status, input ready);
    modport sink (input valid, temperature_k, status, output ready);
endinterface

interface tbt_cfg_if;
    import tbt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/tbt_log2.sv @@
// Three-stage log2 unit: leading-one normalize, table interpolation, sum.
// Depends on tbt_pkg for the mantissa table.
`default_nettype none

module tbt_log2
    import tbt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [23:0]       v,
    output logic      [LOG_W-1:0]  l
);

    logic [4:0]       e_a_reg, e_a_next;
    logic [3:0]       idx_a_reg, idx_a_next;
    logic [18:0]      rem_a_reg, rem_a_next;
    logic [4:0]       e_b_reg;
    logic [16:0]      lo_b_reg, lo_b_next;
    logic [31:0]      prod_b_reg, prod_b_next;
    logic [LOG_W-1:0] l_reg, l_next;
    logic [23:0]      m_c;
    logic [16:0]      hi_c;
    logic [32:0]      rnd_c;

    always_comb
    begin
        e_a_next = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (v[i])
            begin
                e_a_next = 5'(i);
            end
        end
        m_c        = v << (5'd23 - e_a_next);
        idx_a_next = m_c[22:19];
        rem_a_next = m_c[18:0];
    end

    always_comb
    begin
        lo_b_next   = log2_tab({1'b0, idx_a_reg});
        hi_c        = log2_tab(5'({1'b0, idx_a_reg} + 5'd1));
        prod_b_next = 32'({15'd0, 17'(hi_c - lo_b_next)} * {13'd0, rem_a_reg});
    end

    always_comb
    begin
        rnd_c  = {1'b0, prod_b_reg} + 33'd262144;
        l_next = {e_b_reg, 16'd0} + LOG_W'(lo_b_reg) + LOG_W'(rnd_c[32:19]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_a_reg    <= e_a_next;
            idx_a_reg  <= idx_a_next;
            rem_a_reg  <= rem_a_next;
            e_b_reg    <= e_a_reg;
            lo_b_reg   <= lo_b_next;
            prod_b_reg <= prod_b_next;
            l_reg      <= l_next;
        end
    end

    assign l = l_reg;

endmodule

`default_nettype wire

@@ src/tbt_term.sv @@
// Denominator and numerator stages: y*ln2*4800 rounding, D and N, clamp code.
// Depends on tbt_pkg for widths, ln2 constant and the clamp code type.
`default_nettype none

module tbt_term
    import tbt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic signed [Y_W-1:0] y,
    input  wire logic [BETA_W-1:0]     beta,
    output logic [N_W-1:0]             n,
    output logic [D_W-2:0]             d,
    output div_code_t                  code
);

    logic                  sign5_reg, sign6_reg;
    logic [45:0]           mag5_reg, mag5_next;
    logic [58:0]           p6_reg, p6_next;
    logic signed [D_W-1:0] d7_reg, d7_next;
    logic [NUM_W-1:0]      num7_reg, num7_next;
    logic [N_W-1:0]        n8_reg, n8_next;
    logic [D_W-2:0]        d8_reg;
    div_code_t             code8_reg, code8_next;
    logic [Y_W-1:0]        yneg;
    logic [21:0]           ymag;
    logic [58:0]           prnd;
    logic [D_W-1:0]        tmag;
    logic [D_W-1:0]        bsh;
    logic [34:0]           nb;

    always_comb
    begin
        yneg      = -y;
        ymag      = y[Y_W-1] ? yneg[21:0] : y[21:0];
        mag5_next = {24'd0, ymag} * {22'd0, LN2_Q24};
        p6_next   = {13'd0, mag5_reg} * 59'd4800;
    end

    always_comb
    begin
        prnd      = p6_reg + 59'd32768;
        tmag      = {3'd0, prnd[58:16]};
        bsh       = {2'd0, beta, 24'd0};
        d7_next   = sign6_reg ? $signed(bsh - tmag) : $signed(bsh + tmag);
        nb        = {15'd0, beta} * 35'd19200;
        num7_next = {nb, 24'd0};
    end

    always_comb
    begin
        n8_next = {1'b0, num7_reg} + N_W'(d7_reg[D_W-2:1]);
        if (d7_reg[D_W-1])
        begin
            code8_next = DIV_ZERO;
        end
        else if (d7_reg == '0)
        begin
            code8_next = DIV_MAX;
        end
        else if ({1'b0, n8_next} >= {d7_reg[D_W-2:0], 16'd0})
        begin
            code8_next = DIV_MAX;
        end
        else
        begin
            code8_next = DIV_NORM;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign5_reg <= y[Y_W-1];
            mag5_reg  <= mag5_next;
            sign6_reg <= sign5_reg;
            p6_reg    <= p6_next;
            d7_reg    <= d7_next;
            num7_reg  <= num7_next;
            n8_reg    <= n8_next;
            d8_reg    <= d7_reg[D_W-2:0];
            code8_reg <= code8_next;
        end
    end

    assign n    = n8_reg;
    assign d    = d8_reg;
    assign code = code8_reg;

endmodule

`default_nettype wire

@@ src/tbt_div.sv @@
// Sixteen-stage restoring divider, one quotient bit per stage.
// Depends on tbt_pkg for widths and the clamp code type.
`default_nettype none

module tbt_div
    import tbt_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [N_W-1:0] n,
    input  wire logic [D_W-2:0] d,
    input  div_code_t           code_in,
    output logic [QUO_W-1:0]    q,
    output div_code_t           code_out
);

    logic [N_W:0]     rem_reg  [QUO_W];
    logic [D_W-2:0]   dv_reg   [QUO_W];
    logic [QUO_W-1:0] q_reg    [QUO_W];
    div_code_t        code_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int BIT = QUO_W - 1 - k;
        logic [N_W:0]     rem_in, rem_next, dsh;
        logic [D_W-2:0]   dv_in;
        logic [QUO_W-1:0] q_in, q_next;
        div_code_t        code_i;

        if (k == 0)
        begin : g_first
            assign rem_in = {1'b0, n};
            assign dv_in  = d;
            assign q_in   = '0;
            assign code_i = code_in;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign dv_in  = dv_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign code_i = code_reg[k-1];
        end

        always_comb
        begin
            dsh    = (N_W+1)'(dv_in) << BIT;
            q_next = q_in;
            if (rem_in >= dsh)
            begin
                rem_next    = rem_in - dsh;
                q_next[BIT] = 1'b1;
            end
            else
            begin
                rem_next = rem_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                dv_reg[k]   <= dv_in;
                q_reg[k]    <= q_next;
                code_reg[k] <= code_i;
            end
        end
    end

    assign q        = q_reg[QUO_W-1];
    assign code_out = code_reg[QUO_W-1];

endmodule

`default_nettype wire

@@ src/thermistor_beta_temperature_core.sv @@
// Thermistor beta-equation temperature core, top level.
// Depends on tbt_pkg, tbt_if, tbt_log2, tbt_term and tbt_div.
//
//   port       dir   beat
//   sample_ch  sink  adc_sample, adc_read_error
//   result_ch  src   temperature_k (1/64 K), status
//   cfg_ch     sink  index, data (0 reference_ratio, 1 beta_k)
//
// One sample per cycle while result_ch is not held; the pipe has 3 log2 stages, one sum,
// 4 term stages, 16 divider stages and the output register.
// All stages advance together; a held result on result_ch freezes the pipe.
// Reset clears the valid bits and loads the register defaults.
`default_nettype none

module thermistor_beta_temperature_core
    import tbt_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    tbt_sample_if.sink    sample_ch,
    tbt_result_if.source  result_ch,
    tbt_cfg_if.sink       cfg_ch
);

    localparam int PIPE = 8 + QUO_W;
    localparam logic [SAMPLE_W-1:0] FULL = SAMPLE_W'((32'd1 << ADC_BITS) - 32'd1);

    logic [RATIO_W-1:0]  ref_reg;
    logic [BETA_W-1:0]   beta_reg;
    logic [RATIO_W-1:0]  ref_eff;
    logic [BETA_W-1:0]   beta_eff;
    logic                en;
    logic [PIPE-1:0]     vld_reg;
    side_t               side_reg [PIPE];
    side_t               side_in;
    logic [SAMPLE_W-1:0] diff;
    logic [LOG_W-1:0]    l_a, l_r, l_f;
    logic signed [Y_W-1:0] y_reg, y_next;
    logic [N_W-1:0]      n8;
    logic [D_W-2:0]      d8;
    div_code_t           code8, code_q;
    logic [QUO_W-1:0]    q;
    logic                out_vld_reg;
    logic [TEMP_W-1:0]   temp_reg, temp_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg  <= RATIO_W'(65536);
            beta_reg <= BETA_W'(63200);
        end
        else if (cfg_ch.valid)
        begin
            if (cfg_ch.index == REG_REF_RATIO)
            begin
                ref_reg <= cfg_ch.data;
            end
            else if (cfg_ch.index == REG_BETA_K)
            begin
                beta_reg <= cfg_ch.data[BETA_W-1:0];
            end
        end
    end

    assign ref_eff  = (ref_reg == '0) ? RATIO_W'(1) : ref_reg;
    assign beta_eff = (beta_reg == '0) ? BETA_W'(1) : beta_reg;

    assign en              = !out_vld_reg || result_ch.ready;
    assign sample_ch.ready = en;

    assign diff            = FULL - sample_ch.adc_sample;
    assign side_in.invalid = (sample_ch.adc_sample == '0) || (sample_ch.adc_sample >= FULL);
    assign side_in.rd_err  = sample_ch.adc_read_error;

    tbt_log2 u_log_a (.clk(clk), .en(en), .v({8'd0, diff}), .l(l_a));
    tbt_log2 u_log_r (.clk(clk), .en(en), .v({8'd0, sample_ch.adc_sample}), .l(l_r));
    tbt_log2 u_log_f (.clk(clk), .en(en), .v(ref_eff), .l(l_f));

    assign y_next = $signed({2'd0, l_a}) - $signed({2'd0, l_r}) - $signed({2'd0, l_f})
                  + $signed(Y_W'(1048576));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
        end
    end

    tbt_term u_term (
        .clk  (clk),
        .en   (en),
        .y    (y_reg),
        .beta (beta_eff),
        .n    (n8),
        .d    (d8),
        .code (code8)
    );

    tbt_div u_div (
        .clk      (clk),
        .en       (en),
        .n        (n8),
        .d        (d8),
        .code_in  (code8),
        .q        (q),
        .code_out (code_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[PIPE-2:0], sample_ch.valid};
            out_vld_reg <= vld_reg[PIPE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < PIPE; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            temp_reg   <= temp_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        case (code_q)
            DIV_ZERO: temp_next = '0;
            DIV_MAX:  temp_next = '1;
            default:  temp_next = q;
        endcase
        if (side_reg[PIPE-1].invalid)
        begin
            temp_next   = '0;
            status_next = ST_INVALID;
        end
        else if (side_reg[PIPE-1].rd_err)
        begin
            status_next = ST_RD_ERR;
        end
        else if (code_q != DIV_NORM)
        begin
            status_next = ST_SAT;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    assign result_ch.valid         = out_vld_reg;
    assign result_ch.temperature_k = temp_reg;
    assign result_ch.status        = status_reg;

endmodule

`default_nettype wire

@@ sim/thermistor_beta_temperature_core_checker.sv @@
// Checker for the thermistor core: watches sample, result and register channels,
// computes expected temperatures in fixed point and compares each result beat.
// Depends on tbt_pkg and tbt_if.
`timescale 1ns / 100ps

module thermistor_beta_temperature_core_checker
    import tbt_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    tbt_sample_if       sample_ch,
    tbt_result_if       result_ch,
    tbt_cfg_if          cfg_ch,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [TEMP_W-1:0]   temperature_k;
        logic [STATUS_W-1:0] status;
    } temp_beat_t;

    logic [RATIO_W-1:0] ratio_reg;
    logic [BETA_W-1:0]  beta_reg;
    temp_beat_t         temp_queue[$];

    function automatic longint mant_log2(input logic [23:0] v);
        int          e;
        logic [23:0] m;
        logic [22:0] frac;
        logic [3:0]  idx;
        longint      rem;
        longint      lo;
        longint      hi;
        e = 0;
        while (e < 23 && (v >> (e + 1)) != 0)
            e++;
        m = v << (23 - e);
        frac = m[22:0];
        idx = frac[22:19];
        rem = frac[18:0];
        lo = log2_tab({1'b0, idx});
        hi = log2_tab({1'b0, idx} + 5'd1);
        return (longint'(e) << 16) + lo + (((hi - lo) * rem + (64'sd1 <<< 18)) >>> 19);
    endfunction

    function automatic temp_beat_t predict_temp(input logic [15:0] raw, input logic rd_err);
        temp_beat_t  res;
        longint      full;
        longint      rr;
        longint      bb;
        longint      y;
        longint      prod;
        longint      mag;
        longint      d;
        logic [63:0] num;
        logic [63:0] q;
        logic        sat;
        full = (64'sd1 <<< ADC_BITS) - 1;
        rr = (ratio_reg == 0) ? 1 : ratio_reg;
        bb = (beta_reg == 0) ? 1 : beta_reg;
        sat = 1'b0;
        if (raw == 0 || longint'(raw) >= full) begin
            res.temperature_k = '0;
            res.status = ST_INVALID;
            return res;
        end
        y = mant_log2(24'(full - raw)) - mant_log2(24'(raw)) - mant_log2(24'(rr))
            + (64'sd16 <<< 16);
        prod = 64'sd4800 * y * longint'(LN2_Q24);
        mag = (prod < 0) ? -prod : prod;
        mag = (mag + 32768) >>> 16;
        d = (bb <<< 24) + ((prod < 0) ? -mag : mag);
        if (d < 0) begin
            res.temperature_k = '0;
            sat = 1'b1;
        end
        else if (d == 0) begin
            res.temperature_k = '1;
            sat = 1'b1;
        end
        else begin
            num = (64'd19200 * 64'(bb)) << 24;
            q = (num + (64'(d) >> 1)) / 64'(d);
            if (q > 65535) begin
                res.temperature_k = '1;
                sat = 1'b1;
            end
            else
                res.temperature_k = q[15:0];
        end
        res.status = rd_err ? ST_RD_ERR : (sat ? ST_SAT : ST_OK);
        return res;
    endfunction

    assign pending = temp_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        temp_beat_t exp_beat;
        int         errs;
        if (!rst_n)
        begin
            ratio_reg <= RATIO_W'(65536);
            beta_reg <= BETA_W'(63200);
            fail_count <= 0;
            temp_queue.delete();
        end
        else
        begin
            errs = 0;
            if (sample_ch.valid && sample_ch.ready)
                temp_queue.push_back(predict_temp(sample_ch.adc_sample, sample_ch.adc_read_error));
            if (result_ch.valid && result_ch.ready)
            begin
                if (temp_queue.size() == 0)
                begin
                    $error("unexpected result beat temperature_k=%0d status=%0d",
                        result_ch.temperature_k, result_ch.status);
                    errs++;
                end
                else
                begin
                    exp_beat = temp_queue.pop_front();
                    if (exp_beat.temperature_k !== result_ch.temperature_k)
                    begin
                        $error("temperature_k expected %0d actual %0d",
                            exp_beat.temperature_k, result_ch.temperature_k);
                        errs++;
                    end
                    if (exp_beat.status !== result_ch.status)
                    begin
                        $error("status expected %0d actual %0d",
                            exp_beat.status, result_ch.status);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == REG_REF_RATIO)
                    ratio_reg <= cfg_ch.data[RATIO_W-1:0];
                else if (cfg_ch.index == REG_BETA_K)
                    beta_reg <= cfg_ch.data[BETA_W-1:0];
            end
        end
    end

endmodule

@@ sim/thermistor_beta_temperature_core_tb.sv @@
// Testbench top for the thermistor core: clock, reset, sample and register
// stimulus, result back-pressure and the verdict. Depends on tbt_pkg, tbt_if,
// the core and thermistor_beta_temperature_core_checker.
`timescale 1ns / 100ps

module thermistor_beta_temperature_core_tb;
    import tbt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_off = 1'b0;
    int   idle_cycles = 0;

    tbt_sample_if sample_ch();
    tbt_result_if result_ch();
    tbt_cfg_if    cfg_ch();

    thermistor_beta_temperature_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch.sink),
        .result_ch (result_ch.source),
        .cfg_ch    (cfg_ch.sink)
    );

    thermistor_beta_temperature_core_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_ch  (sample_ch),
        .result_ch  (result_ch),
        .cfg_ch     (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        sample_ch.valid = 1'b0;
        sample_ch.adc_sample = '0;
        sample_ch.adc_read_error = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        result_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_off)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_sample(input logic [15:0] raw, input logic rd_err);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.adc_sample <= raw;
        sample_ch.adc_read_error <= rd_err;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    task automatic drain_results();
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(5))
            0:       return 16'($urandom_range(16));
            1:       return 16'(65535 - $urandom_range(16));
            2:       return 16'($urandom_range(28000, 38000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_sample(pick_sample(), ($urandom_range(7) == 0));
        sample_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [23:0] ratio_set[6];
        logic [23:0] beta_set[6];
        ratio_set = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd0, 24'd3000, 24'd700000};
        beta_set = '{24'd63200, 24'd1, 24'hFFFFF, 24'd0, 24'd40000, 24'd100};
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'd1, 1'b0);
        send_sample(16'hFFFE, 1'b0);
        send_sample(16'd32768, 1'b0);
        send_sample(16'd32767, 1'b1);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b1);
        send_sample(16'd2, 1'b1);
        send_sample(16'd65533, 1'b1);
        sample_ch.valid <= 1'b0;
        drain_results();

        for (int s = 0; s < 6; s++)
        begin
            write_reg(REG_REF_RATIO, ratio_set[s]);
            write_reg(REG_BETA_K, beta_set[(s + 1) % 6]);
            case (s % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 49; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 49; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            send_sample(16'd1, 1'b0);
            send_sample(16'hFFFE, 1'b0);
            run_random(120);
            drain_results();
        end

        send_idle_pct = 0;
        stall_pct = 0;
        write_reg(REG_REF_RATIO, 24'd65536);
        write_reg(REG_BETA_K, 24'd63200);
        fork
            begin
                hold_off = 1'b1;
                repeat (200)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            run_random(80);
        join
        drain_results();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
